/* design/pdc_pkg.sv */
package pdc_pkg;

    localparam int DIM_W     = 11;
    localparam int THR_W     = 17;
    localparam int WGT_W     = 5;
    localparam int PIX_W     = 8;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 17;
    localparam int RING_ROWS = 4;
    localparam int LANE_W    = 2;
    localparam int NSUM_W    = 11;
    localparam int PC_W      = WGT_W + PIX_W + 1;
    localparam int PN_W      = WGT_W + NSUM_W + 1;
    localparam int SUM_W     = 18;

    localparam int ROW_AHEAD = RING_ROWS - 1;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_THRESHOLD       = 3'd2,
        REG_CENTER_WEIGHT   = 3'd3,
        REG_NEIGHBOR_WEIGHT = 3'd4
    } reg_index_t;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd512;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd512;
    localparam logic [THR_W-1:0] THR_RST    = 17'd200;
    localparam logic [WGT_W-1:0] CW_RST     = 5'b11000;
    localparam logic [WGT_W-1:0] NW_RST     = 5'b00001;

    localparam logic [PIX_W-1:0] MARK_ON  = 8'hFF;
    localparam logic [PIX_W-1:0] MARK_OFF = 8'h00;

    typedef logic [RING_ROWS-1:0][PIX_W-1:0] ring_word_t;
    typedef logic [2:0][PIX_W-1:0] column_t;

    typedef struct packed {
        logic signed [THR_W-1:0] threshold;
        logic signed [WGT_W-1:0] center_weight;
        logic signed [WGT_W-1:0] neighbor_weight;
    } cfg_t;

    typedef struct packed {
        logic              last;
        logic [LANE_W-1:0] lane_up;
        logic [LANE_W-1:0] lane_mid;
        logic [LANE_W-1:0] lane_dn;
        logic              mask_top;
        logic              mask_bot;
        logic              mask_right;
        logic              first_col;
        logic              fwd_a;
        logic              fwd_b;
        logic [LANE_W-1:0] fwd_lane;
        logic [PIX_W-1:0]  fwd_pix;
    } emit_t;

endpackage

/* design/pdc_line_mem.sv */
module pdc_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [pdc_pkg::LANE_W-1:0]     wr_lane,
    input  logic [pdc_pkg::PIX_W-1:0]      wr_data,
    input  logic                           rd_en,
    input  logic [AW-1:0]                  rd_addr_a,
    input  logic [AW-1:0]                  rd_addr_b,
    output pdc_pkg::ring_word_t            rd_data_a,
    output pdc_pkg::ring_word_t            rd_data_b
);

    pdc_pkg::ring_word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* design/pdc_ctrl.sv */
module pdc_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COL_W      = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          action,
    input  logic [pdc_pkg::PIX_W-1:0]     pixel,
    input  logic                          geom_clear,
    input  logic [pdc_pkg::DIM_W-1:0]     image_width,
    input  logic [pdc_pkg::DIM_W-1:0]     image_height,
    output logic                          emit,
    output pdc_pkg::emit_t                info,
    output logic                          wr_en,
    output logic [COL_W-1:0]              wr_addr,
    output logic [pdc_pkg::LANE_W-1:0]    wr_lane,
    output logic [pdc_pkg::PIX_W-1:0]     wr_data,
    output logic [COL_W-1:0]              rd_addr_a,
    output logic [COL_W-1:0]              rd_addr_b
);

    localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
    localparam int WC_W  = $clog2(MAX_WIDTH + 1);
    localparam int M1_W  = (WC_W > ROW_W) ? WC_W : ROW_W;
    localparam int M2_W  = (M1_W > pdc_pkg::DIM_W) ? M1_W : pdc_pkg::DIM_W;
    localparam int EXT_W = M2_W + 1;

    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;

    logic [EXT_W-1:0] iw_x, ih_x, ew, eh;
    logic [EXT_W-1:0] icol_x, irow_x, ocol_x, orow_x;
    logic [EXT_W-1:0] icol1_x, irow1_x, need_r, need_c;
    logic [COL_W-1:0] in_col_step;
    logic [ROW_W-1:0] in_row_step;
    logic             col_wrap, wr_ok, arrived, in_frame, last, out_wrap;

    always_comb
    begin
        iw_x = EXT_W'(image_width);
        ih_x = EXT_W'(image_height);
        if (iw_x == '0)
            ew = EXT_W'(1);
        else if (iw_x > EXT_W'(MAX_WIDTH))
            ew = EXT_W'(MAX_WIDTH);
        else
            ew = iw_x;
        if (ih_x == '0)
            eh = EXT_W'(1);
        else if (ih_x > EXT_W'(MAX_HEIGHT))
            eh = EXT_W'(MAX_HEIGHT);
        else
            eh = ih_x;

        icol_x = EXT_W'(in_col_reg);
        irow_x = EXT_W'(in_row_reg);
        ocol_x = EXT_W'(out_col_reg);
        orow_x = EXT_W'(out_row_reg);

        wr_ok = (irow_x < eh) && (irow_x < orow_x + EXT_W'(pdc_pkg::ROW_AHEAD))
                && (icol_x < ew);
        wr_en = accept && !action && wr_ok;

        col_wrap    = (icol_x + EXT_W'(1)) >= ew;
        in_col_step = col_wrap ? '0 : in_col_reg + COL_W'(1);
        in_row_step = col_wrap ? in_row_reg + ROW_W'(1) : in_row_reg;

        icol1_x = wr_en ? EXT_W'(in_col_step) : icol_x;
        irow1_x = wr_en ? EXT_W'(in_row_step) : irow_x;

        need_r = ((orow_x + EXT_W'(1)) < eh) ? orow_x + EXT_W'(1) : eh - EXT_W'(1);
        need_c = ((ocol_x + EXT_W'(1)) < ew) ? ocol_x + EXT_W'(1) : ew - EXT_W'(1);
        arrived = (need_r < irow1_x) || ((need_r == irow1_x) && (need_c < icol1_x));
        in_frame = (orow_x < eh) && (ocol_x < ew);
        emit = accept && in_frame && arrived;

        last     = (orow_x == eh - EXT_W'(1)) && (ocol_x == ew - EXT_W'(1));
        out_wrap = (ocol_x + EXT_W'(1)) >= ew;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (geom_clear || (emit && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else
        begin
            if (wr_en)
            begin
                in_col_next = in_col_step;
                in_row_next = in_row_step;
            end
            if (emit)
            begin
                out_col_next = out_wrap ? '0 : out_col_reg + COL_W'(1);
                out_row_next = out_wrap ? out_row_reg + ROW_W'(1) : out_row_reg;
            end
        end

        wr_addr   = in_col_reg;
        wr_lane   = in_row_reg[pdc_pkg::LANE_W-1:0];
        wr_data   = pixel;
        rd_addr_a = out_col_reg + COL_W'(1);
        rd_addr_b = out_col_reg;

        info.last       = last;
        info.lane_mid   = out_row_reg[pdc_pkg::LANE_W-1:0];
        info.lane_up    = out_row_reg[pdc_pkg::LANE_W-1:0] - pdc_pkg::LANE_W'(1);
        info.lane_dn    = out_row_reg[pdc_pkg::LANE_W-1:0] + pdc_pkg::LANE_W'(1);
        info.mask_top   = (orow_x == '0);
        info.mask_bot   = (orow_x + EXT_W'(1)) >= eh;
        info.mask_right = out_wrap;
        info.first_col  = (ocol_x == '0);
        info.fwd_a      = wr_en && (wr_addr == rd_addr_a);
        info.fwd_b      = wr_en && (wr_addr == rd_addr_b);
        info.fwd_lane   = wr_lane;
        info.fwd_pix    = pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

/* design/pdc_datapath.sv */
module pdc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         emit,
    input  pdc_pkg::emit_t               info,
    input  pdc_pkg::ring_word_t          rd_data_a,
    input  pdc_pkg::ring_word_t          rd_data_b,
    input  pdc_pkg::cfg_t                cfg,
    output logic                         s1_ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pdc_pkg::PIX_W-1:0]    m_tdata,
    output logic                         m_tlast
);

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic v1_next, v2_next, v3_next, vo_next;
    logic ready2, ready3, ready_o, adv1, adv2, adv3;

    pdc_pkg::emit_t      info1_reg;
    pdc_pkg::column_t    left_reg;
    pdc_pkg::ring_word_t la, lb;
    pdc_pkg::column_t    col_l, col_c, col_r;

    logic [pdc_pkg::PIX_W-1:0]  center2_reg;
    logic [pdc_pkg::NSUM_W-1:0] nsum, nsum2_reg;
    logic                       last2_reg, last3_reg;

    logic signed [pdc_pkg::PC_W-1:0]  pc, pc3_reg;
    logic signed [pdc_pkg::PN_W-1:0]  pn, pn3_reg;
    logic signed [pdc_pkg::SUM_W-1:0] sum, thr_x;

    logic [pdc_pkg::PIX_W-1:0] mark_reg;
    logic                      tlast_reg;

    always_comb
    begin
        ready_o  = !vo_reg || m_tready;
        ready3   = !v3_reg || ready_o;
        ready2   = !v2_reg || ready3;
        s1_ready = !v1_reg || ready2;
        adv1     = v1_reg && ready2;
        adv2     = v2_reg && ready3;
        adv3     = v3_reg && ready_o;

        v1_next = emit ? 1'b1 : (adv1 ? 1'b0 : v1_reg);
        v2_next = adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_reg);
        v3_next = adv2 ? 1'b1 : (adv3 ? 1'b0 : v3_reg);
        vo_next = adv3 ? 1'b1 : ((vo_reg && m_tready) ? 1'b0 : vo_reg);
    end

    // window columns, with bypass of the pixel written alongside the read
    always_comb
    begin
        la = rd_data_a;
        lb = rd_data_b;
        if (info1_reg.fwd_a)
            la[info1_reg.fwd_lane] = info1_reg.fwd_pix;
        if (info1_reg.fwd_b)
            lb[info1_reg.fwd_lane] = info1_reg.fwd_pix;

        col_r[0] = (info1_reg.mask_top || info1_reg.mask_right) ? '0 : la[info1_reg.lane_up];
        col_r[1] = info1_reg.mask_right ? '0 : la[info1_reg.lane_mid];
        col_r[2] = (info1_reg.mask_bot || info1_reg.mask_right) ? '0 : la[info1_reg.lane_dn];

        col_c[0] = info1_reg.mask_top ? '0 : lb[info1_reg.lane_up];
        col_c[1] = lb[info1_reg.lane_mid];
        col_c[2] = info1_reg.mask_bot ? '0 : lb[info1_reg.lane_dn];

        col_l = info1_reg.first_col ? '0 : left_reg;

        nsum = pdc_pkg::NSUM_W'(col_l[0]) + pdc_pkg::NSUM_W'(col_l[1])
             + pdc_pkg::NSUM_W'(col_l[2]) + pdc_pkg::NSUM_W'(col_c[0])
             + pdc_pkg::NSUM_W'(col_c[2]) + pdc_pkg::NSUM_W'(col_r[0])
             + pdc_pkg::NSUM_W'(col_r[1]) + pdc_pkg::NSUM_W'(col_r[2]);
    end

    always_comb
    begin
        pc    = cfg.center_weight * $signed({1'b0, center2_reg});
        pn    = cfg.neighbor_weight * $signed({1'b0, nsum2_reg});
        sum   = pdc_pkg::SUM_W'(pc3_reg) + pdc_pkg::SUM_W'(pn3_reg);
        thr_x = pdc_pkg::SUM_W'(cfg.threshold);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            info1_reg <= info;
        end
        if (adv1)
        begin
            left_reg    <= col_c;
            center2_reg <= col_c[1];
            nsum2_reg   <= nsum;
            last2_reg   <= info1_reg.last;
        end
        if (adv2)
        begin
            pc3_reg   <= pc;
            pn3_reg   <= pn;
            last3_reg <= last2_reg;
        end
        if (adv3)
        begin
            mark_reg  <= (sum < thr_x) ? pdc_pkg::MARK_ON : pdc_pkg::MARK_OFF;
            tlast_reg <= last3_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = mark_reg;
    assign m_tlast  = tlast_reg;

endmodule

/* design/point_detect_conv3x3_threshold.sv */
// 3x3 point detector with threshold on a raster stream of 8-bit pixels.
// slave channel: one beat per step; tuser is the action (0 pixel, 1 drain),
// tdata the pixel. master channel: tdata is the mark (255 or 0), tlast
// flags the last pixel of the image. a step yields zero or one beat.
// config channel: cfg_index selects width, height, threshold, center and
// neighbor weight; cfg_ready is always high. write only while idle; a
// width or height write restarts the image.
// throughput: one beat per cycle unless stalled. the two line stores and the
// current row sit in one ring memory of four rows, one byte lane per row,
// read at two columns per cycle; that port pair is what sets the rate.
// path: a beat that completes a window passes the memory read, neighbor sum,
// multiply and compare registers before it shows on the master side.
// reset: counters and pipeline valids clear, registers take their defaults;
// memory contents are not cleared.
// stall: results back up in the pipeline and output register; s_tready
// drops only when every stage holds a result.
module point_detect_conv3x3_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // pixel
    input  logic                          s_tuser,    // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,    // mark
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pdc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pdc_pkg::CFG_W-1:0]     cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [pdc_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [pdc_pkg::THR_W-1:0] thr_reg;
    logic [pdc_pkg::WGT_W-1:0] cw_reg, nw_reg;

    logic cfg_wr, geom_clear, accept, emit, s1_ready;
    logic wr_en;
    logic [COL_W-1:0]           wr_addr, rd_addr_a, rd_addr_b;
    logic [pdc_pkg::LANE_W-1:0] wr_lane;
    logic [pdc_pkg::PIX_W-1:0]  wr_data;

    pdc_pkg::emit_t      info;
    pdc_pkg::ring_word_t rd_data_a, rd_data_b;
    pdc_pkg::cfg_t       cfg;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign geom_clear = cfg_wr && ((cfg_index == pdc_pkg::REG_IMAGE_WIDTH)
                                || (cfg_index == pdc_pkg::REG_IMAGE_HEIGHT));
    assign s_tready   = s1_ready;
    assign accept     = s_tvalid && s_tready;

    assign cfg.threshold       = $signed(thr_reg);
    assign cfg.center_weight   = $signed(cw_reg);
    assign cfg.neighbor_weight = $signed(nw_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pdc_pkg::WIDTH_RST;
            height_reg <= pdc_pkg::HEIGHT_RST;
            thr_reg    <= pdc_pkg::THR_RST;
            cw_reg     <= pdc_pkg::CW_RST;
            nw_reg     <= pdc_pkg::NW_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                pdc_pkg::REG_IMAGE_WIDTH:     width_reg  <= cfg_data[pdc_pkg::DIM_W-1:0];
                pdc_pkg::REG_IMAGE_HEIGHT:    height_reg <= cfg_data[pdc_pkg::DIM_W-1:0];
                pdc_pkg::REG_THRESHOLD:       thr_reg    <= cfg_data[pdc_pkg::THR_W-1:0];
                pdc_pkg::REG_CENTER_WEIGHT:   cw_reg     <= cfg_data[pdc_pkg::WGT_W-1:0];
                pdc_pkg::REG_NEIGHBOR_WEIGHT: nw_reg     <= cfg_data[pdc_pkg::WGT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    pdc_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (s_tuser),
        .pixel        (s_tdata),
        .geom_clear   (geom_clear),
        .image_width  (width_reg),
        .image_height (height_reg),
        .emit         (emit),
        .info         (info),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_lane      (wr_lane),
        .wr_data      (wr_data),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b)
    );

    pdc_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_lane   (wr_lane),
        .wr_data   (wr_data),
        .rd_en     (emit),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    pdc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .info      (info),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .cfg       (cfg),
        .s1_ready  (s1_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* design/pdc_checker.sv */
module pdc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_mark_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == 8'hFF) || (m_tdata == 8'h00))
        else $error("mark is neither 255 nor 0");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind point_detect_conv3x3_threshold pdc_checker u_pdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
